>>> rtl/ub_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ub_pkg
// Shared types and constants of the IPv4/UDP header builder.
// ============================================================================
package ub_pkg;

    localparam logic [15:0] VER_TOS_WORD    = 16'h4510;
    localparam logic [15:0] TTL_PROTO_WORD  = 16'h4511;
    localparam logic [15:0] PROTO_UDP       = 16'd17;
    localparam logic [16:0] UDP_HDR_BYTES   = 17'd8;
    localparam logic [16:0] IP_UDP_HDR_BYTES = 17'd28;
    localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;
    localparam logic [15:0] IDENT_RESET     = 16'h4000;
    localparam logic [15:0] PORT_RESET      = 16'd9999;
    localparam logic [15:0] CKSUM_ALL_ONES  = 16'hFFFF;

    localparam logic CFG_SOURCE_PORT      = 1'b0;
    localparam logic CFG_DESTINATION_PORT = 1'b1;

    typedef struct packed {
        logic [15:0] payload_sum;
        logic [16:0] byte_count;
        logic [31:0] source_address;
        logic [31:0] destination_address;
    } pkt_rec_t;

    typedef struct packed {
        logic [15:0] source_port;
        logic [15:0] destination_port;
    } port_cfg_t;

endpackage

>>> rtl/ub_front.sv
`timescale 1ns / 1ps
// ============================================================================
// ub_front
// Accumulates payload bytes into a folded word sum and byte count and
// hands one packet record to the queue on each last word.
// ============================================================================
module ub_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic [7:0]       payload_byte,
    input  logic             byte_valid,
    input  logic             last_item,
    input  logic [31:0]      source_address,
    input  logic [31:0]      destination_address,
    output logic             rec_push,
    output ub_pkg::pkt_rec_t rec_data
);
    import ub_pkg::*;

    logic [15:0] sum_reg, sum_next;
    logic [16:0] count_reg, count_next;
    logic [15:0] addend;
    logic [16:0] raw_sum;
    logic [15:0] folded;
    logic [15:0] sum_acc;
    logic [16:0] count_acc;

    always_comb begin
        addend    = count_reg[0] ? {8'h00, payload_byte} : {payload_byte, 8'h00};
        raw_sum   = {1'b0, sum_reg} + {1'b0, addend};
        folded    = raw_sum[15:0] + {15'd0, raw_sum[16]};
        sum_acc   = byte_valid ? folded : sum_reg;
        count_acc = (byte_valid && (count_reg != COUNT_MAX)) ? count_reg + 17'd1 : count_reg;

        sum_next   = sum_reg;
        count_next = count_reg;
        if (in_accept) begin
            sum_next   = last_item ? 16'd0 : sum_acc;
            count_next = last_item ? 17'd0 : count_acc;
        end

        rec_push                     = in_accept && last_item;
        rec_data.payload_sum         = sum_acc;
        rec_data.byte_count          = count_acc;
        rec_data.source_address      = source_address;
        rec_data.destination_address = destination_address;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= 16'd0;
            count_reg <= 17'd0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/ub_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// ub_queue
// Two-entry queue of packet records between the front and back parts.
// ============================================================================
module ub_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ub_pkg::pkt_rec_t push_data,
    output logic             full,
    output logic             head_valid,
    input  logic             pop,
    output ub_pkg::pkt_rec_t head_data
);
    import ub_pkg::*;

    pkt_rec_t    entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;

    always_comb begin
        full        = (fill_reg == 2'd2);
        head_valid  = (fill_reg != 2'd0);
        head_data   = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> rtl/ub_back.sv
`timescale 1ns / 1ps
// ============================================================================
// ub_back
// Two-stage header datapath: sums the IPv4 and UDP checksum terms, then
// folds, complements and holds the result word for the output channel.
// ============================================================================
module ub_back #(
    parameter int MAX_PAYLOAD = 65507
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  ub_pkg::pkt_rec_t  head_data,
    output logic              pop,
    input  ub_pkg::port_cfg_t port_cfg,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       total_length,
    output logic [15:0]       ident,
    output logic [15:0]       ip_checksum,
    output logic [15:0]       udp_length,
    output logic [15:0]       udp_checksum,
    output logic              size_error
);
    import ub_pkg::*;

    localparam logic [16:0] MaxPayload = 17'(MAX_PAYLOAD);

    logic [15:0] ident_reg, ident_next;
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_err_reg;
    logic [15:0] s1_ident_reg, s1_tot_reg, s1_udp_len_reg;
    logic [18:0] s1_ip_sum_reg;
    logic [19:0] s1_udp_sum_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] tot_out_reg, ident_out_reg, ipck_out_reg, udpl_out_reg, udpck_out_reg;
    logic        err_out_reg;

    logic        s1_ready, s2_load;
    logic        err_c;
    logic [15:0] tot_c, udp_len_c;
    logic [15:0] src_hi, src_lo, dst_hi, dst_lo;
    logic [18:0] ip_sum_c;
    logic [19:0] udp_sum_c;
    logic [16:0] ip_fold_a, udp_fold_a;
    logic [15:0] ip_fold_b, udp_fold_b;
    logic [15:0] udp_ck_c;

    always_comb begin
        out_valid_next = out_valid_reg;
        s2_load        = s1_valid_reg && (!out_valid_reg || out_ready);
        s1_ready       = !s1_valid_reg || s2_load;
        pop            = head_valid && s1_ready;

        err_c     = head_data.byte_count > MaxPayload;
        tot_c     = 16'(head_data.byte_count + IP_UDP_HDR_BYTES);
        udp_len_c = 16'(head_data.byte_count + UDP_HDR_BYTES);
        src_hi    = head_data.source_address[31:16];
        src_lo    = head_data.source_address[15:0];
        dst_hi    = head_data.destination_address[31:16];
        dst_lo    = head_data.destination_address[15:0];

        ip_sum_c = 19'(VER_TOS_WORD) + 19'(TTL_PROTO_WORD) + 19'(tot_c) + 19'(ident_reg)
                 + 19'(src_hi) + 19'(src_lo) + 19'(dst_hi) + 19'(dst_lo);
        udp_sum_c = 20'(src_hi) + 20'(src_lo) + 20'(dst_hi) + 20'(dst_lo)
                  + 20'(PROTO_UDP) + 20'(udp_len_c) + 20'(udp_len_c)
                  + 20'(port_cfg.source_port) + 20'(port_cfg.destination_port)
                  + 20'(head_data.payload_sum);

        ident_next = (pop && !err_c) ? ident_reg + 16'd1 : ident_reg;

        s1_valid_next = s1_valid_reg;
        if (s1_ready) begin
            s1_valid_next = head_valid;
        end

        ip_fold_a  = {1'b0, s1_ip_sum_reg[15:0]} + {14'd0, s1_ip_sum_reg[18:16]};
        ip_fold_b  = ip_fold_a[15:0] + {15'd0, ip_fold_a[16]};
        udp_fold_a = {1'b0, s1_udp_sum_reg[15:0]} + {13'd0, s1_udp_sum_reg[19:16]};
        udp_fold_b = udp_fold_a[15:0] + {15'd0, udp_fold_a[16]};
        udp_ck_c   = (udp_fold_b == CKSUM_ALL_ONES) ? CKSUM_ALL_ONES : ~udp_fold_b;

        if (s2_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_err_reg     <= err_c;
            s1_ident_reg   <= ident_reg;
            s1_tot_reg     <= tot_c;
            s1_udp_len_reg <= udp_len_c;
            s1_ip_sum_reg  <= ip_sum_c;
            s1_udp_sum_reg <= udp_sum_c;
        end
        if (s2_load) begin
            err_out_reg   <= s1_err_reg;
            tot_out_reg   <= s1_err_reg ? 16'd0 : s1_tot_reg;
            ident_out_reg <= s1_err_reg ? 16'd0 : s1_ident_reg;
            ipck_out_reg  <= s1_err_reg ? 16'd0 : ~ip_fold_b;
            udpl_out_reg  <= s1_err_reg ? 16'd0 : s1_udp_len_reg;
            udpck_out_reg <= s1_err_reg ? 16'd0 : udp_ck_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ident_reg     <= IDENT_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            ident_reg     <= ident_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign total_length = tot_out_reg;
    assign ident        = ident_out_reg;
    assign ip_checksum  = ipck_out_reg;
    assign udp_length   = udpl_out_reg;
    assign udp_checksum = udpck_out_reg;
    assign size_error   = err_out_reg;

endmodule

>>> rtl/udp_ipv4_header_builder.sv
`timescale 1ns / 1ps
// ============================================================================
// udp_ipv4_header_builder
// Builds IPv4/UDP length, identification and checksum fields per packet.
// ============================================================================
// Usage:
//   s_ carries one payload byte per word: tdata {destination_address,
//   source_address, payload_byte}, tuser byte_valid, tlast ends the packet.
//   Addresses are sampled on the tlast word only. A tlast word with
//   tuser 0 closes the packet without adding a byte (empty payload).
//   m_ carries one word per packet: tdata {udp_checksum, udp_length,
//   ip_checksum, ident, total_length}, tuser size_error. Oversize packets
//   return all-zero fields with size_error set and use no identification.
//   Ports are written on cfg_wr_en (index 0 source, 1 destination); the user must
//   write them only while idle, which the block does not enforce. Throughput: one
//   byte per cycle while m_ takes its words, including back-to-back one-byte packets.
//   The tlast word's record is written to the queue, summed in the sum stage, then
//   folded and complemented into the output register by the fold stage.
//   A stalled m_ holds its word; the 2-entry record queue then fills and
//   s_tready drops only when both entries are taken.
//   Reset clears sums, counts, the queue and the pipeline, loads
//   identification 0x4000 and both ports with 9999.
// ============================================================================
module udp_ipv4_header_builder #(
    parameter int MAX_PAYLOAD = 65507
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // payload_byte, source_address, destination_address
    input  logic [0:0]  s_tuser,   // byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // total_length, ident, ip_checksum, udp_length, udp_checksum
    output logic [0:0]  m_tuser,   // size_error
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wr_data
);
    import ub_pkg::*;

    logic      in_accept;
    logic      rec_push, q_full, head_valid, pop;
    pkt_rec_t  rec_data, head_data;
    port_cfg_t cfg_reg, cfg_next;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SOURCE_PORT:      cfg_next.source_port      = cfg_wr_data;
                CFG_DESTINATION_PORT: cfg_next.destination_port = cfg_wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_port      <= PORT_RESET;
            cfg_reg.destination_port <= PORT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ub_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_accept           (in_accept),
        .payload_byte        (s_tdata[7:0]),
        .byte_valid          (s_tuser[0]),
        .last_item           (s_tlast),
        .source_address      (s_tdata[39:8]),
        .destination_address (s_tdata[71:40]),
        .rec_push            (rec_push),
        .rec_data            (rec_data)
    );

    ub_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (rec_push),
        .push_data  (rec_data),
        .full       (q_full),
        .head_valid (head_valid),
        .pop        (pop),
        .head_data  (head_data)
    );

    ub_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .port_cfg     (cfg_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .total_length (m_tdata[15:0]),
        .ident        (m_tdata[31:16]),
        .ip_checksum  (m_tdata[47:32]),
        .udp_length   (m_tdata[63:48]),
        .udp_checksum (m_tdata[79:64]),
        .size_error   (m_tuser[0])
    );

endmodule

>>> rtl/ub_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ub_checker
// Port-level checks of the header builder result channel.
// ============================================================================
module ub_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 80'd0)
        else $error("oversize result carries nonzero fields");

    a_udp_ck_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[79:64] != 16'd0)
        else $error("UDP checksum sent as zero");

    a_len_rel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == m_tdata[63:48] + 16'd20)
        else $error("total length and UDP length disagree");

endmodule

bind udp_ipv4_header_builder ub_checker u_ub_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench for the IPv4/UDP header builder.
// Directed packets drive payload extremes, empty payloads, invalid bytes and
// a forced all-ones UDP checksum. Random packets follow under several port
// settings. A behavioral predictor computes each result but the first empty
// packet's fixed header; results are compared field by field in arrival order.
// Random idling runs on both sides, with one long receiver hold-off.
// ============================================================================
module tb;
    import ub_pkg::*;

    localparam int PAYLOAD_LIMIT  = 65507;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 310;
    localparam int HOLD_CYCLES    = 120;
    localparam int NUM_ROWS       = 9;

    typedef struct packed {
        logic [15:0] total_length;
        logic [15:0] ident;
        logic [15:0] ip_checksum;
        logic [15:0] udp_length;
        logic [15:0] udp_checksum;
        logic        size_error;
    } udp_hdr_t;

    typedef struct packed {
        logic [17:0] nbytes;
        logic [16:0] reps;
        logic        rnd;
        logic [15:0] word;
        logic        gap_inv;
        logic        end_inv;
        logic [31:0] src;
        logic [31:0] dst;
        logic        typed;
        udp_hdr_t    hdr;
    } pkt_row_t;

    localparam udp_hdr_t FIRST_EMPTY_HDR =
        '{16'd28, 16'h4000, 16'h35C2, 16'd8, 16'hB1C0, 1'b0};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // payload_byte, source_address, destination_address
    logic [0:0]  s_tuser;   // byte_valid
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // total_length, ident, ip_checksum, udp_length, udp_checksum
    logic [0:0]  m_tuser;   // size_error
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [15:0] cfg_wr_data;

    logic [31:0] sum_acc;
    logic [16:0] bytes_seen;
    logic [15:0] ident_next;
    logic [15:0] src_port;
    logic [15:0] dst_port;

    udp_hdr_t    pending_hdrs[$];
    pkt_row_t    dir_rows[NUM_ROWS];
    int          mismatches;
    int          items_sent;
    int          idle_cycles;
    bit          calm;
    bit          hold_req;
    bit          hold_done;

    udp_ipv4_header_builder #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [31:0] ones_fold(input logic [31:0] s);
        logic [31:0] t;
        t = s;
        while (t[31:16] != 16'd0)
            t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
        return t;
    endfunction

    function automatic logic [31:0] add_address(input logic [31:0] s, input logic [31:0] a);
        return ones_fold(s + {16'd0, a[31:16]} + {16'd0, a[15:0]});
    endfunction

    function automatic bit predict_header(input logic [7:0] b, input logic v, input logic l,
                                          input logic [31:0] src, input logic [31:0] dst,
                                          output udp_hdr_t r);
        logic [31:0] s;
        logic [31:0] tot;
        logic [31:0] ulen;
        logic [15:0] ck;
        r = '0;
        if (v) begin
            if (!bytes_seen[0])
                sum_acc = ones_fold(sum_acc + {16'd0, b, 8'd0});
            else
                sum_acc = ones_fold(sum_acc + {24'd0, b});
            if (bytes_seen != '1)
                bytes_seen = bytes_seen + 17'd1;
        end
        if (!l)
            return 1'b0;
        if (bytes_seen > PAYLOAD_LIMIT) begin
            r.size_error = 1'b1;
        end else begin
            ulen = {15'd0, bytes_seen} + 32'd8;
            tot  = {15'd0, bytes_seen} + 32'd28;
            s = ones_fold(32'h4510 + tot + {16'd0, ident_next} + 32'h4511);
            s = add_address(s, src);
            s = add_address(s, dst);
            r.total_length = tot[15:0];
            r.ident        = ident_next;
            r.ip_checksum  = ~s[15:0];
            r.udp_length   = ulen[15:0];
            s = add_address(32'd0, src);
            s = add_address(s, dst);
            s = ones_fold(s + 32'd17 + ulen);
            s = ones_fold(s + {16'd0, src_port} + {16'd0, dst_port} + ulen);
            s = ones_fold(s + sum_acc);
            ck = ~s[15:0];
            if (ck == 16'd0)
                ck = 16'hFFFF;
            r.udp_checksum = ck;
            ident_next = ident_next + 16'd1;
        end
        sum_acc    = 32'd0;
        bytes_seen = 17'd0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_addr();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return 32'h0;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    // drive one word at the falling edge and hold it until accepted
    task automatic send_word(input logic [7:0] b, input logic v, input logic l,
                             input logic [31:0] src, input logic [31:0] dst,
                             input logic typed, input udp_hdr_t hdr);
        udp_hdr_t pred;
        while (!calm && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dst, src, b};
        s_tuser  <= v;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        if (predict_header(b, v, l, src, dst, pred))
            pending_hdrs.insert(pending_hdrs.size(), typed ? hdr : pred);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_packet(input int nbytes, input logic rnd, input logic [15:0] word,
                               input logic gap_inv, input logic end_inv,
                               input logic [31:0] src, input logic [31:0] dst,
                               input logic typed, input udp_hdr_t hdr);
        logic [7:0] b;
        logic       close_inv;
        close_inv = end_inv || (nbytes == 0);
        for (int i = 0; i < nbytes; i++) begin
            if (gap_inv && i == nbytes / 2)
                send_word(8'($urandom), 1'b0, 1'b0, $urandom, $urandom, 1'b0, '0);
            b = rnd ? 8'($urandom) : (i[0] ? word[7:0] : word[15:8]);
            if (!close_inv && i == nbytes - 1)
                send_word(b, 1'b1, 1'b1, src, dst, typed, hdr);
            else
                send_word(b, 1'b1, 1'b0, $urandom, $urandom, 1'b0, '0);
        end
        if (close_inv)
            send_word(8'($urandom), 1'b0, 1'b1, src, dst, typed, hdr);
    endtask

    task automatic set_ports(input logic [15:0] sp, input logic [15:0] dp);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_SOURCE_PORT;
        cfg_wr_data <= sp;
        @(negedge aclk);
        cfg_addr    <= CFG_DESTINATION_PORT;
        cfg_wr_data <= dp;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        src_port = sp;
        dst_port = dp;
    endtask

    // wait out every expected word plus the pipeline depth
    task automatic drain();
        while (pending_hdrs.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_phase(input int items, input int calm_pkts);
        int start;
        int pkts;
        int n;
        int sel;
        start = items_sent;
        pkts  = 0;
        while (items_sent - start < items) begin
            sel = $urandom_range(99);
            if (sel < 12)
                n = 0;
            else if (sel < 80)
                n = $urandom_range(24, 1);
            else
                n = $urandom_range(160, 25);
            calm = (pkts < calm_pkts);
            send_packet(n, 1'b1, 16'h0, $urandom_range(99) < 15, $urandom_range(99) < 20,
                        rand_addr(), rand_addr(), 1'b0, '0);
            pkts++;
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        drain();
    endtask

    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_tready <= calm || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge aclk) begin
        udp_hdr_t want;
        udp_hdr_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                    m_tdata[79:64], m_tuser[0]};
            if (pending_hdrs.size() == 0) begin
                $error("result word with none expected: %h", got);
                mismatches++;
            end else begin
                want = pending_hdrs.pop_front();
                check_field("total_length", want.total_length, got.total_length);
                check_field("ident", want.ident, got.ident);
                check_field("ip_checksum", want.ip_checksum, got.ip_checksum);
                check_field("udp_length", want.udp_length, got.udp_length);
                check_field("udp_checksum", want.udp_checksum, got.udp_checksum);
                check_field("size_error", {15'd0, want.size_error}, {15'd0, got.size_error});
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = CFG_SOURCE_PORT;
        cfg_wr_data = '0;
        aresetn     = 1'b0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        items_sent  = 0;
        sum_acc     = 32'd0;
        bytes_seen  = 17'd0;
        ident_next  = 16'h4000;
        src_port    = 16'd9999;
        dst_port    = 16'd9999;

        // nbytes, reps, rnd, word, gap_inv, end_inv, src, dst, typed, hdr
        dir_rows[0]  = '{18'd0, 17'd1, 1'b0, 16'h0000, 1'b0, 1'b1,
                         32'h0, 32'h0, 1'b1, FIRST_EMPTY_HDR};
        dir_rows[1]  = '{18'd1, 17'd1, 1'b0, 16'h0000, 1'b0, 1'b0,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0};
        dir_rows[2]  = '{18'd1, 17'd1, 1'b0, 16'hFFFF, 1'b0, 1'b0,
                         32'h0, 32'hFFFF_FFFF, 1'b0, '0};
        dir_rows[3]  = '{18'd2, 17'd1, 1'b0, 16'hFFFF, 1'b0, 1'b0,
                         32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0};
        dir_rows[4]  = '{18'd3, 17'd1, 1'b1, 16'h0000, 1'b1, 1'b0,
                         32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0};
        dir_rows[5]  = '{18'd4, 17'd1, 1'b1, 16'h0000, 1'b0, 1'b1,
                         32'h0A00_0001, 32'h0A00_0002, 1'b0, '0};
        dir_rows[6]  = '{18'd2, 17'd1, 1'b0, 16'hB1BC, 1'b0, 1'b0,
                         32'h0, 32'h0, 1'b0, '0};
        dir_rows[7]  = '{18'd1, 17'd1, 1'b1, 16'h0000, 1'b0, 1'b0,
                         32'h0A00_0003, 32'h0A00_0004, 1'b0, '0};
        dir_rows[8]  = '{18'd5, 17'd1, 1'b1, 16'h0000, 1'b1, 1'b1,
                         32'h8000_0001, 32'h0000_8001, 1'b0, '0};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < NUM_ROWS; i++)
            repeat (dir_rows[i].reps)
                send_packet(dir_rows[i].nbytes, dir_rows[i].rnd, dir_rows[i].word,
                            dir_rows[i].gap_inv, dir_rows[i].end_inv, dir_rows[i].src,
                            dir_rows[i].dst, dir_rows[i].typed, dir_rows[i].hdr);
        s_tvalid <= 1'b0;
        drain();

        // hold the result side while one-byte packets keep coming
        calm     = 1'b1;
        hold_req = 1'b1;
        repeat (30)
            send_packet(1, 1'b1, 16'h0, 1'b0, 1'b0, rand_addr(), rand_addr(), 1'b0, '0);
        calm = 1'b0;
        s_tvalid <= 1'b0;
        drain();

        set_ports(16'h0000, 16'h0000);
        run_phase(PHASE_ITEMS, 0);
        set_ports(16'hFFFF, 16'hFFFF);
        run_phase(PHASE_ITEMS, 0);
        set_ports(16'($urandom), 16'($urandom));
        run_phase(PHASE_ITEMS, 30);
        set_ports(16'hFFFF, 16'h0000);
        run_phase(PHASE_ITEMS, 0);

        if (mismatches == 0 && pending_hdrs.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
